// ===== src/coalesced_hash_table_macros.svh =====
// Assertion macros for the hash table RTL
`ifndef COALESCED_HASH_TABLE_MACROS_SVH
`define COALESCED_HASH_TABLE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define CHT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define CHT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define CHT_ASSERT(label, clk, rst_n, prop, msg)
`define CHT_ASSERT_NEXT(label, clk, rst_n, pre, post, msg)
`endif
`endif

// ===== src/cht_pkg.sv =====
package cht_pkg;

  localparam int unsigned TableSizeDefault = 256;
  localparam logic [31:0] EmptyKey = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    OpInsert = 2'd0,
    OpLookup = 2'd1,
    OpRemove = 2'd2,
    OpUnused = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    StDone     = 2'd0,
    StNotFound = 2'd1,
    StFull     = 2'd2
  } status_e;

  // Request as classified by the front end
  typedef struct packed {
    logic [1:0]  opcode;
    logic [31:0] key;
    logic [31:0] value;
    logic        bypass;
  } req_t;

  typedef enum logic [4:0] {
    SIdle,
    SWalkRd,
    SWalkChk,
    SInsRd,
    SInsChk,
    SPutDec,
    SScan,
    SPutFree,
    SPutLink,
    SEvRd,
    SEvChk,
    SUnlinkRd,
    SUnlinkChk,
    SEvPlace,
    SReRd,
    SReChk,
    SReply
  } be_state_e;

endpackage

// ===== src/cht_front.sv =====
module cht_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [1:0]    opcode_i,
  input  logic [31:0]   key_i,
  input  logic [31:0]   value_i,
  output logic          req_valid_o,
  input  logic          req_take_i,
  output cht_pkg::req_t req_o
);

  // Two-entry request queue
  cht_pkg::req_t buf_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    cnt_q;
  logic          wr, rd;
  cht_pkg::req_t req_in;

  // Classify: reserved key and unused opcode answer without touching the table
  always_comb begin
    req_in.opcode = opcode_i;
    req_in.key    = key_i;
    req_in.value  = value_i;
    req_in.bypass = (key_i == cht_pkg::EmptyKey) ||
                    (opcode_i == cht_pkg::OpUnused);
  end

  assign full_o      = cnt_q[1];
  assign wr          = push_i && !full_o;
  assign req_valid_o = cnt_q != 2'd0;
  assign rd          = req_take_i && req_valid_o;
  assign req_o       = buf_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (wr) begin
      buf_q[wr_ptr_q] <= req_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= 2'd0;
    end else begin
      if (wr) wr_ptr_q <= !wr_ptr_q;
      if (rd) rd_ptr_q <= !rd_ptr_q;
      cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
    end
  end

endmodule

// ===== src/cht_back.sv =====
`include "coalesced_hash_table_macros.svh"

module cht_back #(
  parameter int unsigned TableSize = cht_pkg::TableSizeDefault,
  localparam int unsigned Aw = $clog2(TableSize)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          req_valid_i,
  output logic          req_take_o,
  input  cht_pkg::req_t req_i,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [1:0]    status_o,
  output logic [31:0]   found_value_o
);

  typedef struct packed {
    logic [31:0]   key;
    logic [31:0]   data;
    logic [Aw-1:0] link;
    logic          live;
    logic          link_ok;
  } slot_t;

  localparam slot_t UnusedSlot = '{key: cht_pkg::EmptyKey, data: '0, link: '0,
                                   live: 1'b0, link_ok: 1'b0};
  localparam logic [Aw:0] LastStep = (Aw+1)'(TableSize - 1);

  // Slot memory, one read port with registered data, one write port
  slot_t                slot_mem [TableSize];
  logic [TableSize-1:0] used_q;
  slot_t                rd_q;
  logic                 rd_en;
  logic [Aw-1:0]        rd_addr;
  logic                 wr_en;
  logic [Aw-1:0]        wr_addr;
  slot_t                wr_data;

  cht_pkg::be_state_e state_q, state_d;
  cht_pkg::req_t      req_q;
  slot_t              hw_q, hw_d;              // home word of the slot being filled
  logic [Aw-1:0]      slot_q, slot_d;          // walk pointer / found free slot
  logic [Aw:0]        cnt_q, cnt_d;            // walk step bound
  logic [Aw-1:0]      cur_q, cur_d;            // free cursor
  logic               exh_q, exh_d;
  logic [Aw-1:0]      sc_q, sc_d;              // scan cursor (uncommitted)
  logic               sexh_q, sexh_d;
  logic               probe_q, probe_d;        // scan only checks, commits nothing
  logic [31:0]        k2_q, k2_d, v2_q, v2_d;
  logic               l2_q, l2_d;
  logic [31:0]        put_key_q, put_key_d, put_val_q, put_val_d;
  logic [Aw-1:0]      put_home_q, put_home_d;
  logic               reins_q, reins_d;        // placing evicted entry
  cht_pkg::status_e   st_q, st_d;
  logic [31:0]        fv_q, fv_d;
  logic               out_valid_q;
  logic               load_out;

  logic [Aw-1:0] home, home_k2, sc_next;
  logic          sexh_next, key_hit, walk_stop;
  logic          put_needs_free, ev_needs_free;

  assign home      = req_q.key[Aw-1:0];
  assign home_k2   = k2_q[Aw-1:0];
  assign sc_next   = (sc_q == '0) ? sc_q : sc_q - Aw'(1);
  assign sexh_next = sexh_q || (sc_q == '0);
  assign key_hit   = (rd_q.key == req_q.key);
  assign walk_stop = (key_hit && (req_q.opcode == cht_pkg::OpRemove || rd_q.live)) ||
                     !rd_q.link_ok || cnt_q == LastStep;
  // Home blocks direct placement unless unused or a dead self-owned entry
  assign put_needs_free = !(hw_q.key == cht_pkg::EmptyKey ||
                            (hw_q.key[Aw-1:0] == put_home_q && !hw_q.live));
  assign ev_needs_free  = !(rd_q.key == cht_pkg::EmptyKey ||
                            (rd_q.key[Aw-1:0] == home_k2 && !rd_q.live));
  assign load_out = (state_q == cht_pkg::SReply) && (!out_valid_q || pop_i);

  // Memory ports; unused slots read as empty
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      slot_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= used_q[rd_addr] ? slot_mem[rd_addr] : UnusedSlot;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cht_pkg::SIdle: begin
        if (req_valid_i) begin
          if (req_i.bypass) state_d = cht_pkg::SReply;
          else if (req_i.opcode == cht_pkg::OpInsert) state_d = cht_pkg::SInsRd;
          else state_d = cht_pkg::SWalkRd;
        end
      end
      cht_pkg::SWalkRd: state_d = cht_pkg::SWalkChk;
      cht_pkg::SWalkChk: begin
        if (walk_stop) state_d = cht_pkg::SReply;
        else state_d = cht_pkg::SWalkRd;
      end
      cht_pkg::SInsRd: state_d = cht_pkg::SInsChk;
      cht_pkg::SInsChk: begin
        if (rd_q.key == cht_pkg::EmptyKey || rd_q.key[Aw-1:0] == home)
          state_d = cht_pkg::SPutDec;
        else if (rd_q.live) state_d = cht_pkg::SEvRd;
        else state_d = cht_pkg::SUnlinkRd;
      end
      cht_pkg::SPutDec: begin
        if (put_needs_free) state_d = cht_pkg::SScan;
        else state_d = cht_pkg::SReply;
      end
      cht_pkg::SScan: begin
        if (sexh_q) state_d = cht_pkg::SReply;
        else if (!used_q[sc_q]) state_d = probe_q ? cht_pkg::SUnlinkRd : cht_pkg::SPutFree;
      end
      cht_pkg::SPutFree: state_d = cht_pkg::SPutLink;
      cht_pkg::SPutLink: state_d = cht_pkg::SReply;
      cht_pkg::SEvRd: state_d = cht_pkg::SEvChk;
      cht_pkg::SEvChk: begin
        if (ev_needs_free) state_d = cht_pkg::SScan;
        else state_d = cht_pkg::SUnlinkRd;
      end
      cht_pkg::SUnlinkRd: state_d = cht_pkg::SUnlinkChk;
      cht_pkg::SUnlinkChk: begin
        if (!rd_q.link_ok || rd_q.link == home || cnt_q == LastStep)
          state_d = cht_pkg::SEvPlace;
        else state_d = cht_pkg::SUnlinkRd;
      end
      cht_pkg::SEvPlace: begin
        if (l2_q) state_d = cht_pkg::SReRd;
        else state_d = cht_pkg::SReply;
      end
      cht_pkg::SReRd: state_d = cht_pkg::SReChk;
      cht_pkg::SReChk: state_d = cht_pkg::SPutDec;
      cht_pkg::SReply: if (load_out) state_d = cht_pkg::SIdle;
      default: state_d = cht_pkg::SIdle;
    endcase
  end

  // Datapath and outputs per state
  always_comb begin
    req_take_o = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = slot_q;
    wr_en      = 1'b0;
    wr_addr    = slot_q;
    wr_data    = rd_q;
    hw_d       = hw_q;
    slot_d     = slot_q;
    cnt_d      = cnt_q;
    cur_d      = cur_q;
    exh_d      = exh_q;
    sc_d       = sc_q;
    sexh_d     = sexh_q;
    probe_d    = probe_q;
    k2_d       = k2_q;
    v2_d       = v2_q;
    l2_d       = l2_q;
    put_key_d  = put_key_q;
    put_val_d  = put_val_q;
    put_home_d = put_home_q;
    reins_d    = reins_q;
    st_d       = st_q;
    fv_d       = fv_q;
    case (state_q)
      cht_pkg::SIdle: begin
        req_take_o = 1'b1;
        slot_d     = req_i.key[Aw-1:0];
        cnt_d      = '0;
        reins_d    = 1'b0;
        probe_d    = 1'b0;
        st_d       = cht_pkg::StNotFound;
        fv_d       = '0;
      end
      cht_pkg::SWalkRd: begin
        rd_en = 1'b1;
      end
      cht_pkg::SWalkChk: begin
        if (key_hit && req_q.opcode == cht_pkg::OpRemove) begin
          // mark dead, keep it linked
          wr_en        = 1'b1;
          wr_data.live = 1'b0;
          if (rd_q.live) begin
            st_d = cht_pkg::StDone;
            fv_d = rd_q.data;
          end
        end else if (key_hit && rd_q.live) begin
          st_d = cht_pkg::StDone;
          fv_d = rd_q.data;
        end else begin
          slot_d = rd_q.link;
          cnt_d  = cnt_q + (Aw+1)'(1);
        end
      end
      cht_pkg::SInsRd: begin
        rd_en   = 1'b1;
        rd_addr = home;
      end
      cht_pkg::SInsChk: begin
        hw_d = rd_q;
        if (rd_q.key == cht_pkg::EmptyKey || rd_q.key[Aw-1:0] == home) begin
          put_key_d  = req_q.key;
          put_val_d  = req_q.value;
          put_home_d = home;
        end else begin
          // foreign entry sits in home: evict it
          k2_d   = rd_q.key;
          v2_d   = rd_q.data;
          l2_d   = rd_q.live;
          slot_d = rd_q.key[Aw-1:0];
          cnt_d  = '0;
        end
      end
      cht_pkg::SPutDec: begin
        if (put_needs_free) begin
          sc_d    = cur_q;
          sexh_d  = exh_q;
          probe_d = 1'b0;
        end else begin
          wr_en   = 1'b1;
          wr_addr = put_home_q;
          wr_data = '{key: put_key_q, data: put_val_q, link: hw_q.link,
                      live: 1'b1, link_ok: hw_q.link_ok};
          st_d    = cht_pkg::StDone;
        end
      end
      cht_pkg::SScan: begin
        if (sexh_q) begin
          st_d = reins_q ? cht_pkg::StDone : cht_pkg::StFull;
        end else if (!used_q[sc_q]) begin
          if (probe_q) begin
            slot_d = home_k2;
            cnt_d  = '0;
          end else begin
            slot_d = sc_q;
            cur_d  = sc_next;
            exh_d  = sexh_next;
          end
        end else begin
          sc_d   = sc_next;
          sexh_d = sexh_next;
        end
      end
      cht_pkg::SPutFree: begin
        wr_en   = 1'b1;
        wr_data = '{key: put_key_q, data: put_val_q, link: hw_q.link,
                    live: 1'b1, link_ok: hw_q.link_ok};
      end
      cht_pkg::SPutLink: begin
        wr_en           = 1'b1;
        wr_addr         = put_home_q;
        wr_data         = hw_q;
        wr_data.link    = slot_q;
        wr_data.link_ok = 1'b1;
        st_d            = cht_pkg::StDone;
      end
      cht_pkg::SEvRd: begin
        rd_en   = 1'b1;
        rd_addr = home_k2;
      end
      cht_pkg::SEvChk: begin
        if (ev_needs_free) begin
          sc_d    = cur_q;
          sexh_d  = exh_q;
          probe_d = 1'b1;
        end else begin
          slot_d = home_k2;
          cnt_d  = '0;
        end
      end
      cht_pkg::SUnlinkRd: begin
        rd_en = 1'b1;
      end
      cht_pkg::SUnlinkChk: begin
        if (rd_q.link_ok && rd_q.link == home) begin
          // take over the evicted slot's successor
          wr_en           = 1'b1;
          wr_data.link    = hw_q.link;
          wr_data.link_ok = hw_q.link_ok;
        end else begin
          slot_d = rd_q.link;
          cnt_d  = cnt_q + (Aw+1)'(1);
        end
      end
      cht_pkg::SEvPlace: begin
        wr_en      = 1'b1;
        wr_addr    = home;
        wr_data    = '{key: req_q.key, data: req_q.value, link: '0,
                       live: 1'b1, link_ok: 1'b0};
        st_d       = cht_pkg::StDone;
        put_key_d  = k2_q;
        put_val_d  = v2_q;
        put_home_d = home_k2;
        reins_d    = l2_q;
      end
      cht_pkg::SReRd: begin
        rd_en   = 1'b1;
        rd_addr = put_home_q;
      end
      cht_pkg::SReChk: begin
        hw_d = rd_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= cht_pkg::SIdle;
      used_q      <= '0;
      cur_q       <= Aw'(TableSize - 1);
      exh_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cur_q   <= cur_d;
      exh_q   <= exh_d;
      if (wr_en) used_q[wr_addr] <= 1'b1;
      if (load_out) out_valid_q <= 1'b1;
      else if (pop_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == cht_pkg::SIdle && req_valid_i) req_q <= req_i;
    hw_q       <= hw_d;
    slot_q     <= slot_d;
    cnt_q      <= cnt_d;
    sc_q       <= sc_d;
    sexh_q     <= sexh_d;
    probe_q    <= probe_d;
    k2_q       <= k2_d;
    v2_q       <= v2_d;
    l2_q       <= l2_d;
    put_key_q  <= put_key_d;
    put_val_q  <= put_val_d;
    put_home_q <= put_home_d;
    reins_q    <= reins_d;
    st_q       <= st_d;
    fv_q       <= fv_d;
    if (load_out) begin
      status_o      <= st_q;
      found_value_o <= fv_q;
    end
  end

  assign empty_o = !out_valid_q;

  `CHT_ASSERT(a_found_zero, clk_i, rst_ni, !(out_valid_q && status_o != cht_pkg::StDone && found_value_o != '0), "nonzero value with failure status")
  `CHT_ASSERT_NEXT(a_take_idle, clk_i, rst_ni, req_take_o && req_valid_i, state_q != cht_pkg::SIdle, "request taken but back end idle")
  `CHT_ASSERT(a_status_code, clk_i, rst_ni, !(out_valid_q && status_o > cht_pkg::StFull), "illegal status code")
  `CHT_ASSERT_NEXT(a_hold_beat, clk_i, rst_ni, out_valid_q && !pop_i, out_valid_q && $stable(status_o) && $stable(found_value_o), "waiting result beat changed")

endmodule

// ===== src/coalesced_hash_table.sv =====
// Coalesced-chaining hash table, 32-bit keys and values.
// Request side: push with opcode_i/key_i/value_i, taken while full is low.
// Result side: one beat per request on status_o/found_value_o while empty
// is low, consumed with pop. Results come back in request order.
// A front stage classifies requests into a two-beat queue; a back-end
// sequencer walks the chain through a slot memory with one read port and
// one write port. A reserved key or unused opcode is answered without
// touching the table. A lookup or remove reads its home slot and then
// follows the chain one step at a time. An insert reads its home slot and
// writes there, or scans for a free slot and links it after its home. An
// insert that evicts adds the evicted home read, a free-slot check, the
// unlink steps and a re-insert. The back end serves one request at a time.
// Reset empties the table (valid bits cleared at once, no clearing pass),
// drops queued requests and resets the free cursor to the top slot.
// When pop stays low, one result waits at the output and the back end
// holds its next result until the beat is taken; the front queue then fills
// and full rises.
module coalesced_hash_table #(
  parameter int unsigned TableSize = cht_pkg::TableSizeDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  opcode_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        empty,
  input  logic        pop,
  output logic [1:0]  status_o,
  output logic [31:0] found_value_o
);

  logic          req_valid, req_take;
  cht_pkg::req_t req;

  cht_front u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full),
    .opcode_i, .key_i, .value_i,
    .req_valid_o(req_valid), .req_take_i(req_take), .req_o(req)
  );

  cht_back #(.TableSize(TableSize)) u_back (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_take_o(req_take), .req_i(req),
    .empty_o(empty), .pop_i(pop),
    .status_o, .found_value_o
  );

endmodule
